// File: design/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg: shared definitions for the request timeout table
// Request codes, status codes, sequencer states and compare unit types.
// ----------------------------------------------------------------------------
package rtt_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int HANDLE_BITS_DEF = 8;
   localparam int STORE_BITS_DEF  = 8;

   localparam int DEADLINE_BITS = 32;
   localparam int USER_BITS     = 8;
   localparam int IPC_BITS      = 31;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_DEL_KEY   = 3'd2;
   localparam logic [2:0] OP_DEL_IDX   = 3'd3;
   localparam logic [2:0] OP_READ      = 3'd4;
   localparam logic [2:0] OP_DEL_STORE = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMP_RD,
      ST_CMP_EV,
      ST_CMP_END,
      ST_INS_RD,
      ST_INS_EV,
      ST_GET_RD,
      ST_GET_EV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CMP_KEY,
      CMP_STORE,
      CMP_INDEX
   } cmp_mode_type;

   typedef struct packed {
      logic hit;
      logic later;
   } cmp_res_type;

endpackage

// File: design/rtt_ram.sv
// ----------------------------------------------------------------------------
// rtt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/rtt_cmp.sv
// ----------------------------------------------------------------------------
// rtt_cmp: shared compare unit
// Matches a table entry by key, by store or by index, and orders deadlines.
// ----------------------------------------------------------------------------
module rtt_cmp #(
   parameter int HANDLE_BITS = rtt_pkg::HANDLE_BITS_DEF,
   parameter int STORE_BITS  = rtt_pkg::STORE_BITS_DEF,
   parameter int INDEX_BITS  = 6
) (
   input  rtt_pkg::cmp_mode_type             mode,
   input  logic [HANDLE_BITS-1:0]            ent_handle,
   input  logic [STORE_BITS-1:0]             ent_store,
   input  logic [rtt_pkg::DEADLINE_BITS-1:0] ent_deadline,
   input  logic [INDEX_BITS-1:0]             ent_index,
   input  logic [HANDLE_BITS-1:0]            ref_handle,
   input  logic [STORE_BITS-1:0]             ref_store,
   input  logic [7:0]                        ref_index,
   input  logic [rtt_pkg::DEADLINE_BITS-1:0] ref_deadline,
   output rtt_pkg::cmp_res_type              res
);

   always_comb begin
      res.later = ent_deadline > ref_deadline;
      unique case (mode)
         rtt_pkg::CMP_KEY:   res.hit = (ent_handle == ref_handle) && (ent_store == ref_store);
         rtt_pkg::CMP_STORE: res.hit = ent_store == ref_store;
         rtt_pkg::CMP_INDEX: res.hit = 32'(ent_index) == 32'(ref_index);
         default:            res.hit = 1'b0;
      endcase
   end

endmodule

// File: design/request_timeout_table.sv
// ----------------------------------------------------------------------------
// request_timeout_table: outstanding requests sorted by deadline
// Sequencer around a one-write, one-read table RAM and a shared compare unit.
// ----------------------------------------------------------------------------
// One request word is handled at a time and the block stalls its input until
// the response word is staged. Every table read goes through the one RAM
// read port. Deletes, but for an index delete out of range, sweep all occupied
// entries. An add first sweeps for the key and then walks down from the top
// of the table to the insertion point, moving each later entry up by one. A
// response waits in an output register while the next request word is
// accepted.
// ----------------------------------------------------------------------------
module request_timeout_table #(
   parameter int TABLE_DEPTH = rtt_pkg::TABLE_DEPTH_DEF,
   parameter int HANDLE_BITS = rtt_pkg::HANDLE_BITS_DEF,
   parameter int STORE_BITS  = rtt_pkg::STORE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_handle_type,
   input  logic [7:0]  req_store_id,
   input  logic [7:0]  req_user_id,
   input  logic [30:0] req_ipc_code,
   input  logic [31:0] req_wait_time,
   input  logic [7:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_entry_handle,
   output logic [7:0]  rsp_entry_store,
   output logic [7:0]  rsp_entry_user,
   output logic [30:0] rsp_entry_ipc,
   output logic [31:0] rsp_entry_deadline,
   output logic [5:0]  rsp_entry_total,
   output logic        rsp_timer_running,
   output logic [5:0]  rsp_removed_total
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int DLB    = rtt_pkg::DEADLINE_BITS;
   localparam int IPC_LO = 0;
   localparam int USR_LO = IPC_LO + rtt_pkg::IPC_BITS;
   localparam int HND_LO = USR_LO + rtt_pkg::USER_BITS;
   localparam int STO_LO = HND_LO + HANDLE_BITS;
   localparam int DL_LO  = STO_LO + STORE_BITS;
   localparam int EW     = DL_LO + DLB;

   rtt_pkg::state_type    state_ff, state_in;
   rtt_pkg::cmp_mode_type mode_ff, mode_in;
   rtt_pkg::cmp_res_type  cmp_res;

   logic [CW-1:0]          occ_ff, occ_in, rd_ff, rd_in, wr_ff, wr_in, rem_ff, rem_in;
   logic [CW-1:0]          occ_new;
   logic [DLB-1:0]         beat_ff, beat_in, dl_ff, dl_in;
   logic                   run_ff, run_in, found_ff, found_in;
   logic [2:0]             op_ff, op_in;
   logic [HANDLE_BITS-1:0] hnd_ff, hnd_in;
   logic [STORE_BITS-1:0]  sto_ff, sto_in;
   logic [7:0]             usr_ff, usr_in, pos_ff, pos_in;
   logic [30:0]            ipc_ff, ipc_in;
   logic [31:0]            wait_ff, wait_in;
   logic [1:0]             status_ff, status_in;
   logic [EW-1:0]          get_ff, get_in;
   logic                   get_ok_ff, get_ok_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_handle_ff, rsp_handle_in;
   logic [7:0]             rsp_store_ff, rsp_store_in;
   logic [7:0]             rsp_user_ff, rsp_user_in;
   logic [30:0]            rsp_ipc_ff, rsp_ipc_in;
   logic [31:0]            rsp_dl_ff, rsp_dl_in;
   logic [5:0]             rsp_total_ff, rsp_total_in;
   logic                   rsp_run_ff, rsp_run_in;
   logic [5:0]             rsp_rem_ff, rsp_rem_in;

   logic                   accept, pos_ok, rsp_free;
   logic                   ram_we, ram_re;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [EW-1:0]          ram_wdata, ram_rdata, new_entry;

   assign accept   = req_valid && (state_ff == rtt_pkg::ST_IDLE);
   assign pos_ok   = 32'(req_position) < 32'(occ_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign occ_new  = occ_ff - rem_ff;
   assign new_entry = {dl_ff, sto_ff, hnd_ff, usr_ff, ipc_ff};

   rtt_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rtt_cmp #(
      .HANDLE_BITS (HANDLE_BITS),
      .STORE_BITS  (STORE_BITS),
      .INDEX_BITS  (CW)
   ) u_cmp (
      .mode         (mode_ff),
      .ent_handle   (ram_rdata[HND_LO +: HANDLE_BITS]),
      .ent_store    (ram_rdata[STO_LO +: STORE_BITS]),
      .ent_deadline (ram_rdata[DL_LO +: DLB]),
      .ent_index    (rd_ff),
      .ref_handle   (hnd_ff),
      .ref_store    (sto_ff),
      .ref_index    (pos_ff),
      .ref_deadline (dl_ff),
      .res          (cmp_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  rtt_pkg::OP_ADD, rtt_pkg::OP_DEL_KEY, rtt_pkg::OP_DEL_STORE:
                     state_in = rtt_pkg::ST_CMP_RD;
                  rtt_pkg::OP_DEL_IDX:
                     state_in = pos_ok ? rtt_pkg::ST_CMP_RD : rtt_pkg::ST_DONE;
                  rtt_pkg::OP_READ:
                     state_in = pos_ok ? rtt_pkg::ST_GET_RD : rtt_pkg::ST_DONE;
                  default:
                     state_in = rtt_pkg::ST_DONE;
               endcase
            end
         end
         rtt_pkg::ST_CMP_RD:
            state_in = (rd_ff < occ_ff) ? rtt_pkg::ST_CMP_EV : rtt_pkg::ST_CMP_END;
         rtt_pkg::ST_CMP_EV:
            state_in = rtt_pkg::ST_CMP_RD;
         rtt_pkg::ST_CMP_END: begin
            if ((op_ff == rtt_pkg::OP_ADD) &&
                (found_ff || (32'(occ_new) < 32'(TABLE_DEPTH)))) begin
               state_in = rtt_pkg::ST_INS_RD;
            end else begin
               state_in = rtt_pkg::ST_DONE;
            end
         end
         rtt_pkg::ST_INS_RD:
            state_in = (rd_ff == '0) ? rtt_pkg::ST_DONE : rtt_pkg::ST_INS_EV;
         rtt_pkg::ST_INS_EV:
            state_in = cmp_res.later ? rtt_pkg::ST_INS_RD : rtt_pkg::ST_DONE;
         rtt_pkg::ST_GET_RD:
            state_in = rtt_pkg::ST_GET_EV;
         rtt_pkg::ST_GET_EV:
            state_in = rtt_pkg::ST_DONE;
         rtt_pkg::ST_DONE:
            state_in = rsp_free ? rtt_pkg::ST_IDLE : rtt_pkg::ST_DONE;
         default:
            state_in = rtt_pkg::ST_IDLE;
      endcase
   end

   // Table RAM controls.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wr_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = rd_ff[AW-1:0];
      unique case (state_ff)
         rtt_pkg::ST_CMP_RD: begin
            ram_re = rd_ff < occ_ff;
         end
         rtt_pkg::ST_CMP_EV: begin
            ram_we = !cmp_res.hit;
         end
         rtt_pkg::ST_INS_RD: begin
            if (rd_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
               ram_wdata = new_entry;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = AW'(rd_ff - CW'(1));
            end
         end
         rtt_pkg::ST_INS_EV: begin
            ram_we    = 1'b1;
            ram_waddr = rd_ff[AW-1:0];
            ram_wdata = cmp_res.later ? ram_rdata : new_entry;
         end
         rtt_pkg::ST_GET_RD: begin
            ram_re    = 1'b1;
            ram_raddr = AW'(pos_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      occ_in    = occ_ff;
      beat_in   = beat_ff;
      run_in    = run_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      rem_in    = rem_ff;
      found_in  = found_ff;
      dl_in     = dl_ff;
      mode_in   = mode_ff;
      op_in     = op_ff;
      hnd_in    = hnd_ff;
      sto_in    = sto_ff;
      usr_in    = usr_ff;
      pos_in    = pos_ff;
      ipc_in    = ipc_ff;
      wait_in   = wait_ff;
      status_in = status_ff;
      get_in    = get_ff;
      get_ok_in = get_ok_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_store_in  = rsp_store_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_ipc_in    = rsp_ipc_ff;
      rsp_dl_in     = rsp_dl_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_rem_in    = rsp_rem_ff;

      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = req_type;
               hnd_in    = HANDLE_BITS'(req_handle_type);
               sto_in    = STORE_BITS'(req_store_id);
               usr_in    = req_user_id;
               ipc_in    = req_ipc_code;
               wait_in   = req_wait_time;
               pos_in    = req_position;
               rd_in     = '0;
               wr_in     = '0;
               rem_in    = '0;
               found_in  = 1'b0;
               get_ok_in = 1'b0;
               status_in = rtt_pkg::STATUS_OK;
               case (req_type)
                  rtt_pkg::OP_TICK: begin
                     if (run_ff) begin
                        beat_in = beat_ff + DLB'(1);
                     end
                  end
                  rtt_pkg::OP_DEL_IDX: begin
                     mode_in = rtt_pkg::CMP_INDEX;
                     if (!pos_ok) begin
                        status_in = rtt_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  rtt_pkg::OP_READ: begin
                     if (!pos_ok) begin
                        status_in = rtt_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  rtt_pkg::OP_DEL_STORE: mode_in = rtt_pkg::CMP_STORE;
                  default:               mode_in = rtt_pkg::CMP_KEY;
               endcase
            end
         end
         rtt_pkg::ST_CMP_EV: begin
            rd_in = rd_ff + CW'(1);
            if (cmp_res.hit) begin
               rem_in = rem_ff + CW'(1);
               // A re-armed entry keeps the request code it was first added with.
               if ((mode_ff == rtt_pkg::CMP_KEY) && (op_ff == rtt_pkg::OP_ADD)) begin
                  found_in = 1'b1;
                  ipc_in   = ram_rdata[IPC_LO +: rtt_pkg::IPC_BITS];
               end else begin
                  found_in = 1'b1;
               end
            end else begin
               wr_in = wr_ff + CW'(1);
            end
         end
         rtt_pkg::ST_CMP_END: begin
            occ_in = occ_new;
            if (occ_new == '0) begin
               beat_in = '0;
               run_in  = 1'b0;
            end
            if ((op_ff == rtt_pkg::OP_DEL_KEY) && !found_ff) begin
               status_in = rtt_pkg::STATUS_NOT_FOUND;
            end
            if (op_ff == rtt_pkg::OP_ADD) begin
               if (found_ff || (32'(occ_new) < 32'(TABLE_DEPTH))) begin
                  rd_in = occ_new;
                  if (occ_new == '0) begin
                     run_in = 1'b1;
                     dl_in  = wait_ff;
                  end else begin
                     dl_in  = beat_ff + wait_ff;
                  end
               end else begin
                  status_in = rtt_pkg::STATUS_FULL;
               end
            end
         end
         rtt_pkg::ST_INS_RD: begin
            if (rd_ff == '0) begin
               occ_in = occ_ff + CW'(1);
            end
         end
         rtt_pkg::ST_INS_EV: begin
            if (cmp_res.later) begin
               rd_in = rd_ff - CW'(1);
            end else begin
               occ_in = occ_ff + CW'(1);
            end
         end
         rtt_pkg::ST_GET_EV: begin
            get_in    = ram_rdata;
            get_ok_in = 1'b1;
         end
         rtt_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_handle_in = get_ok_ff ? 8'(get_ff[HND_LO +: HANDLE_BITS]) : '0;
               rsp_store_in  = get_ok_ff ? 8'(get_ff[STO_LO +: STORE_BITS]) : '0;
               rsp_user_in   = get_ok_ff ? get_ff[USR_LO +: rtt_pkg::USER_BITS] : '0;
               rsp_ipc_in    = get_ok_ff ? get_ff[IPC_LO +: rtt_pkg::IPC_BITS] : '0;
               rsp_dl_in     = get_ok_ff ? get_ff[DL_LO +: DLB] : '0;
               rsp_total_in  = 6'(occ_ff);
               rsp_run_in    = run_ff;
               rsp_rem_in    = (op_ff == rtt_pkg::OP_ADD) ? 6'd0 : 6'(rem_ff);
            end
         end
         default: begin
            rd_in = rd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtt_pkg::ST_IDLE;
         occ_ff       <= '0;
         beat_ff      <= '0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         beat_ff      <= beat_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      rem_ff        <= rem_in;
      found_ff      <= found_in;
      dl_ff         <= dl_in;
      mode_ff       <= mode_in;
      op_ff         <= op_in;
      hnd_ff        <= hnd_in;
      sto_ff        <= sto_in;
      usr_ff        <= usr_in;
      pos_ff        <= pos_in;
      ipc_ff        <= ipc_in;
      wait_ff       <= wait_in;
      status_ff     <= status_in;
      get_ff        <= get_in;
      get_ok_ff     <= get_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_store_ff  <= rsp_store_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_ipc_ff    <= rsp_ipc_in;
      rsp_dl_ff     <= rsp_dl_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_rem_ff    <= rsp_rem_in;
   end

   assign req_stall          = state_ff != rtt_pkg::ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_handle   = rsp_handle_ff;
   assign rsp_entry_store    = rsp_store_ff;
   assign rsp_entry_user     = rsp_user_ff;
   assign rsp_entry_ipc      = rsp_ipc_ff;
   assign rsp_entry_deadline = rsp_dl_ff;
   assign rsp_entry_total    = rsp_total_ff;
   assign rsp_timer_running  = rsp_run_ff;
   assign rsp_removed_total  = rsp_rem_ff;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the request timeout table
// Drives request words from a queue with bursty gaps, stalls responses on a
// pattern, and checks each response word against a predictor of the table.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH      = 32;
   localparam int LIMIT      = 900000;
   localparam int OP_SPARE_A = 6;
   localparam int OP_SPARE_B = 7;

   typedef struct {
      logic [2:0]  op;
      logic [7:0]  handle;
      logic [7:0]  store;
      logic [7:0]  user;
      logic [30:0] ipc;
      logic [31:0] wait_beats;
      logic [7:0]  position;
      bit          drain;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  handle;
      logic [7:0]  store;
      logic [7:0]  user;
      logic [30:0] ipc;
      logic [31:0] deadline;
      logic [5:0]  total;
      logic        running;
      logic [5:0]  removed;
   } response_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0]  req_type = 0;
   logic [7:0]  req_handle_type = 0;
   logic [7:0]  req_store_id = 0;
   logic [7:0]  req_user_id = 0;
   logic [30:0] req_ipc_code = 0;
   logic [31:0] req_wait_time = 0;
   logic [7:0]  req_position = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_entry_handle;
   logic [7:0]  rsp_entry_store;
   logic [7:0]  rsp_entry_user;
   logic [30:0] rsp_entry_ipc;
   logic [31:0] rsp_entry_deadline;
   logic [5:0]  rsp_entry_total;
   logic        rsp_timer_running;
   logic [5:0]  rsp_removed_total;

   request_timeout_table u_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Predictor state: the sorted table.
   logic [31:0] tbl_deadline[DEPTH];
   logic [15:0] tbl_key[DEPTH];
   logic [7:0]  tbl_user[DEPTH];
   logic [30:0] tbl_ipc[DEPTH];
   int          tbl_count;
   logic [31:0] beats;
   logic        timer_on;

   request_type  pending_words[$];
   response_type expected_words[$];
   int errors;
   int cycles;
   int accepted;
   int full_hits, rearms, store_sweeps;
   bit stimulus_done;

   function automatic int find_entry(logic [15:0] key);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < tbl_count; i++) begin
         tbl_deadline[i] = tbl_deadline[i+1];
         tbl_key[i]      = tbl_key[i+1];
         tbl_user[i]     = tbl_user[i+1];
         tbl_ipc[i]      = tbl_ipc[i+1];
      end
      tbl_count--;
      if (tbl_count == 0) begin
         beats    = '0;
         timer_on = 1'b0;
      end
   endfunction

   function automatic void place_entry(logic [15:0] key, logic [7:0] user, logic [30:0] ipc,
                                       logic [31:0] wt);
      logic [31:0] due;
      int pos;
      if (tbl_count == 0) timer_on = 1'b1;
      due = beats + wt;
      pos = 0;
      while (pos < tbl_count && tbl_deadline[pos] <= due) pos++;
      for (int i = tbl_count; i > pos; i--) begin
         tbl_deadline[i] = tbl_deadline[i-1];
         tbl_key[i]      = tbl_key[i-1];
         tbl_user[i]     = tbl_user[i-1];
         tbl_ipc[i]      = tbl_ipc[i-1];
      end
      tbl_deadline[pos] = due;
      tbl_key[pos]      = key;
      tbl_user[pos]     = user;
      tbl_ipc[pos]      = ipc;
      tbl_count++;
   endfunction

   function automatic response_type apply_request(request_type r);
      response_type e;
      logic [15:0] key;
      logic [30:0] kept;
      int f;
      e = '{default: 0};
      key = {r.store, r.handle};
      case (r.op)
         rtt_pkg::OP_TICK: if (timer_on) beats++;
         rtt_pkg::OP_ADD: begin
            f = find_entry(key);
            if (f >= 0) begin
               kept = tbl_ipc[f];
               drop_entry(f);
               place_entry(key, r.user, kept, r.wait_beats);
               rearms++;
            end else if (tbl_count >= DEPTH) begin
               e.status = rtt_pkg::STATUS_FULL;
               full_hits++;
            end else place_entry(key, r.user, r.ipc, r.wait_beats);
         end
         rtt_pkg::OP_DEL_KEY: begin
            f = find_entry(key);
            if (f >= 0) begin
               drop_entry(f);
               e.removed = 6'd1;
            end else e.status = rtt_pkg::STATUS_NOT_FOUND;
         end
         rtt_pkg::OP_DEL_IDX: begin
            if (r.position < tbl_count) begin
               drop_entry(r.position);
               e.removed = 6'd1;
            end else e.status = rtt_pkg::STATUS_NOT_FOUND;
         end
         rtt_pkg::OP_READ: begin
            if (r.position < tbl_count) begin
               e.handle   = tbl_key[r.position][7:0];
               e.store    = tbl_key[r.position][15:8];
               e.user     = tbl_user[r.position];
               e.ipc      = tbl_ipc[r.position];
               e.deadline = tbl_deadline[r.position];
            end else e.status = rtt_pkg::STATUS_NOT_FOUND;
         end
         rtt_pkg::OP_DEL_STORE: begin
            f = 0;
            store_sweeps++;
            while (f < tbl_count) begin
               if (tbl_key[f][15:8] == r.store) begin
                  drop_entry(f);
                  e.removed++;
               end else f++;
            end
         end
         default: ;
      endcase
      e.total   = 6'(tbl_count);
      e.running = timer_on;
      return e;
   endfunction

   function automatic request_type make_request(int op, int h, int s, int pos, logic [31:0] wt);
      request_type r;
      r.op         = 3'(op);
      r.handle     = 8'(h);
      r.store      = 8'(s);
      r.user       = 8'($urandom);
      r.ipc        = 31'($urandom);
      r.wait_beats = wt;
      r.position   = 8'(pos);
      r.drain      = 1'b0;
      return r;
   endfunction

   // Driver: bursts of words separated by random gaps.
   int  gap_left;
   int  burst_left;
   bit  holding;
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 0;
         gap_left   = 0;
         burst_left = 0;
         holding    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_words.push_back(apply_request(pending_words.pop_front()));
            accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_words.size() > 0 && pending_words[0].drain) begin
               holding = 1;
               if (expected_words.size() == 0 && !rsp_valid) begin
                  void'(pending_words.pop_front());
                  holding = 0;
               end
            end
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            if (holding || pending_words.size() == 0 || pending_words[0].drain) begin
               req_valid <= 0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 0;
            end else begin
               burst_left--;
               req_valid       <= 1;
               req_type        <= pending_words[0].op;
               req_handle_type <= pending_words[0].handle;
               req_store_id    <= pending_words[0].store;
               req_user_id     <= pending_words[0].user;
               req_ipc_code    <= pending_words[0].ipc;
               req_wait_time   <= pending_words[0].wait_beats;
               req_position    <= pending_words[0].position;
            end
         end
      end
   end

   // Monitor: stall pattern of its own, check each accepted response word.
   int stall_phase;
   always @(posedge clock) begin
      response_type e;
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("response word with nothing expected");
               errors++;
            end else begin
               e = expected_words.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); errors++; end
               if (rsp_entry_handle !== e.handle) begin
                  $error("entry_handle exp %0h got %0h", e.handle, rsp_entry_handle);
                  errors++; end
               if (rsp_entry_store !== e.store) begin
                  $error("entry_store exp %0h got %0h", e.store, rsp_entry_store); errors++; end
               if (rsp_entry_user !== e.user) begin
                  $error("entry_user exp %0h got %0h", e.user, rsp_entry_user); errors++; end
               if (rsp_entry_ipc !== e.ipc) begin
                  $error("entry_ipc exp %0h got %0h", e.ipc, rsp_entry_ipc); errors++; end
               if (rsp_entry_deadline !== e.deadline) begin
                  $error("entry_deadline exp %0h got %0h", e.deadline, rsp_entry_deadline);
                  errors++; end
               if (rsp_entry_total !== e.total) begin
                  $error("entry_total exp %0d got %0d", e.total, rsp_entry_total); errors++; end
               if (rsp_timer_running !== e.running) begin
                  $error("timer_running exp %0d got %0d", e.running, rsp_timer_running);
                  errors++; end
               if (rsp_removed_total !== e.removed) begin
                  $error("removed_total exp %0d got %0d", e.removed, rsp_removed_total);
                  errors++; end
            end
         end
         // Alternates between long free-flowing stretches and choppy stalling.
         stall_phase = (stall_phase + 1) % 300;
         rsp_stall <= (stall_phase < 120) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
   end

   initial begin
      request_type r;
      int op, h, s, n;
      logic [31:0] wt;
      errors = 0; cycles = 0; accepted = 0; stall_phase = 0;
      full_hits = 0; rearms = 0; store_sweeps = 0; stimulus_done = 0;
      tbl_count = 0; beats = '0; timer_on = 1'b0;

      // Directed part: extremes, each request code and the corner cases.
      pending_words.push_back(make_request(rtt_pkg::OP_TICK, 0, 0, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_READ, 0, 0, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_DEL_KEY, 255, 255, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_DEL_IDX, 0, 0, 255, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_ADD, 255, 255, 0, 32'hFFFF_FFFF));
      pending_words.push_back(make_request(rtt_pkg::OP_TICK, 0, 0, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_ADD, 0, 0, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_ADD, 1, 0, 0, 0));
      r = make_request(rtt_pkg::OP_ADD, 170, 85, 0, 5); r.user = 8'hFF; r.ipc = '1;
      pending_words.push_back(r);
      pending_words.push_back(make_request(rtt_pkg::OP_READ, 0, 0, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_READ, 0, 0, 3, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_ADD, 0, 0, 0, 7));
      pending_words.push_back(make_request(rtt_pkg::OP_READ, 0, 0, 2, 0));
      pending_words.push_back(make_request(OP_SPARE_A, 0, 0, 0, 0));
      pending_words.push_back(make_request(OP_SPARE_B, 255, 255, 255, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_DEL_IDX, 0, 0, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_DEL_STORE, 0, 0, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_DEL_STORE, 0, 255, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_DEL_STORE, 0, 85, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_ADD, 9, 9, 0, 100));
      pending_words.push_back(make_request(rtt_pkg::OP_ADD, 9, 9, 0, 1));
      pending_words.push_back(make_request(rtt_pkg::OP_DEL_KEY, 9, 9, 0, 0));
      pending_words.push_back(make_request(rtt_pkg::OP_TICK, 0, 0, 0, 0));

      // Random part: small key space so rearms, deletes and a full table occur.
      for (int i = 0; i < 1280; i++) begin
         if (i % 400 == 200) begin
            r = make_request(rtt_pkg::OP_TICK, 0, 0, 0, 0); r.drain = 1'b1;
            pending_words.push_back(r);
         end
         n = $urandom_range(0, 99);
         if (n < 35)      op = rtt_pkg::OP_ADD;
         else if (n < 55) op = rtt_pkg::OP_TICK;
         else if (n < 67) op = rtt_pkg::OP_READ;
         else if (n < 77) op = rtt_pkg::OP_DEL_KEY;
         else if (n < 85) op = rtt_pkg::OP_DEL_IDX;
         else if (n < 89) op = rtt_pkg::OP_DEL_STORE;
         else if (n < 91) op = $urandom_range(OP_SPARE_A, OP_SPARE_B);
         else             op = rtt_pkg::OP_ADD;
         if (i % 300 < 150) begin
            h = $urandom_range(0, 15); s = $urandom_range(0, 3);
         end else begin
            h = $urandom_range(0, 255); s = $urandom_range(0, 255);
         end
         case ($urandom_range(0, 4))
            0: wt = $urandom;
            1: wt = $urandom_range(0, 3);
            2: wt = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: wt = $urandom_range(0, 200);
         endcase
         r = make_request(op, h, s, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 33), wt);
         pending_words.push_back(r);
      end
      r = make_request(rtt_pkg::OP_TICK, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 0;
      wait (pending_words.size() == 0);
      stimulus_done = 1;
   end

   // End of run: drain, allow the block's latency, then report.
   initial begin
      int settle;
      settle = 0;
      while (cycles < LIMIT && !(stimulus_done && expected_words.size() == 0 && settle > 200)) begin
         @(posedge clock);
         if (stimulus_done && expected_words.size() == 0) settle++;
         else settle = 0;
      end
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
      end else begin
         $display("%0d request words checked: %0d table-full adds, %0d rearms, %0d store sweeps",
                  accepted, full_hits, rearms, store_sweeps);
         if (errors == 0) $display("TEST PASSED");
         else $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/rtt_pkg.sv
design/rtt_ram.sv
design/rtt_cmp.sv
design/request_timeout_table.sv
test/tb.sv
